// ----- sv/ordered_list_engine_top_defines.svh -----
// Assertion macros for the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OLE_ASSERT_IMPL(label, ante, cons)
`define OLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants and codes of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;
    localparam int CAPACITY_DEF = 32;

    localparam logic [3:0] REQ_INS_FRONT  = 4'd0;
    localparam logic [3:0] REQ_INS_BACK   = 4'd1;
    localparam logic [3:0] REQ_INS_BEFORE = 4'd2;
    localparam logic [3:0] REQ_INS_AFTER  = 4'd3;
    localparam logic [3:0] REQ_DEL_FRONT  = 4'd4;
    localparam logic [3:0] REQ_DEL_BACK   = 4'd5;
    localparam logic [3:0] REQ_DEL_KEY    = 4'd6;
    localparam logic [3:0] REQ_SEARCH     = 4'd7;
    localparam logic [3:0] REQ_DUMP       = 4'd8;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] data;
        logic        last;
    } result_t;
endpackage

// ----- sv/ole_out_buf.sv -----
// ----------------------------------------------------------------------------
// ole_out_buf
// Two-entry result buffer, sequencer to output; space only while it is empty.
// ----------------------------------------------------------------------------
module ole_out_buf
    import ole_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    empty,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);
    result_t    buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = buf_reg[rd_reg];
    assign space     = cnt_reg == 2'd0;
    assign empty     = cnt_reg == 2'd0;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push)
                wr_reg <= ~wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= push_data;
    end
endmodule

// ----- sv/ole_core.sv -----
// ----------------------------------------------------------------------------
// ole_core
// Link memories and the walk/update sequencer of the ordered list.
// ----------------------------------------------------------------------------
module ole_core
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [3:0]  req_type,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        idle,
    input  logic        res_space,
    output logic        res_push,
    output result_t     res_data
);
    `include "ordered_list_engine_top_defines.svh"

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NUL = IW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [31:0]   val_mem [CAPACITY];
    logic [IW-1:0] nxt_mem [CAPACITY];

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [3:0]    req_reg;
    logic [31:0]   key_reg, val_reg;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prv_reg, prv_next;
    logic [IW-1:0] stp_reg, stp_next;
    logic [1:0]    upd_reg, upd_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    result_t       res_reg, res_next;
    logic          res_last_emit_reg, res_last_emit_next;

    // memory port controls
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_val;
    logic [IW-1:0] rd_nxt;
    logic          wv_en, wn_en;
    logic [AW-1:0] wv_addr, wn_addr;
    logic [IW-1:0] wn_data;

    logic full, step_end;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_val <= val_mem[rd_addr];
            rd_nxt <= nxt_mem[rd_addr];
        end
        if (wv_en)
            val_mem[wv_addr] <= val_reg;
        if (wn_en)
            nxt_mem[wn_addr] <= wn_data;
    end

    assign full     = (free_reg >= NUL) || (count_reg >= NUL);
    assign idle     = state_reg == S_IDLE;
    assign res_data = res_reg;
    // current node is read back in S_EVAL; step count bounded by capacity
    assign step_end = (stp_reg + 1'b1) >= NUL;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        prv_next   = prv_reg;
        stp_next   = stp_reg;
        upd_next   = upd_reg;
        tgt_next   = tgt_reg;
        res_next   = res_reg;
        res_last_emit_next = res_last_emit_reg;
        rd_en   = 1'b0;
        rd_addr = cur_reg[AW-1:0];
        wv_en   = 1'b0;
        wv_addr = free_reg[AW-1:0];
        wn_en   = 1'b0;
        wn_addr = free_reg[AW-1:0];
        wn_data = NUL;
        res_push = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wn_en    = 1'b1;
                wn_addr  = clr_reg[AW-1:0];
                wn_data  = clr_reg + 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg + 1'b1 >= NUL)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                res_next = '{status: ST_DONE, position: '0, data: '0, last: 1'b1};
                cur_next = head_reg;
                prv_next = NUL;
                stp_next = '0;
                if (req_reg <= REQ_INS_AFTER && full)
                begin
                    res_next.status = ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    case (req_reg)
                        REQ_INS_FRONT:
                        begin
                            upd_next = 2'd0;
                            state_next = S_UPD;
                        end
                        REQ_DEL_FRONT:
                        begin
                            if (head_reg >= NUL)
                            begin
                                res_next.status = ST_MISS;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = head_reg[AW-1:0];
                                upd_next = 2'd0;
                                state_next = S_UPD;
                            end
                        end
                        REQ_INS_BACK, REQ_DEL_BACK, REQ_INS_BEFORE, REQ_INS_AFTER,
                        REQ_DEL_KEY, REQ_SEARCH, REQ_DUMP:
                        begin
                            if (head_reg >= NUL)
                            begin
                                if (req_reg == REQ_INS_BACK)
                                begin
                                    upd_next = 2'd1;
                                    state_next = S_UPD;
                                end
                                else
                                begin
                                    res_next.status = ST_MISS;
                                    state_next = S_EMIT;
                                end
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = head_reg[AW-1:0];
                                state_next = S_EVAL;
                            end
                        end
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_EVAL:
            begin
                // rd_val/rd_nxt hold entry cur_reg
                if (req_reg == REQ_DUMP)
                begin
                    res_next = '{status: ST_DONE, position: '0, data: rd_val,
                                 last: (rd_nxt >= NUL) || step_end};
                    state_next = S_WALK;
                end
                else if (req_reg == REQ_INS_BACK || req_reg == REQ_DEL_BACK)
                begin
                    if (rd_nxt >= NUL || step_end)
                    begin
                        upd_next = 2'd1;
                        state_next = S_UPD;
                    end
                    else
                    begin
                        prv_next = cur_reg;
                        cur_next = rd_nxt;
                        stp_next = stp_reg + 1'b1;
                        rd_en = 1'b1;
                        rd_addr = rd_nxt[AW-1:0];
                    end
                end
                else if (rd_val == key_reg)
                begin
                    tgt_next = rd_nxt;
                    if (req_reg == REQ_SEARCH)
                    begin
                        res_next.position = 6'(stp_reg) + 6'd1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        upd_next = 2'd2;
                        state_next = S_UPD;
                    end
                end
                else if (rd_nxt >= NUL || step_end)
                begin
                    res_next.status = ST_MISS;
                    state_next = S_EMIT;
                end
                else
                begin
                    prv_next = cur_reg;
                    cur_next = rd_nxt;
                    stp_next = stp_reg + 1'b1;
                    rd_en = 1'b1;
                    rd_addr = rd_nxt[AW-1:0];
                end
            end
            S_WALK:
            begin
                // dump: push one result when there is space, then fetch the next entry unless it was the last
                if (res_space)
                begin
                    res_push = 1'b1;
                    if (res_reg.last)
                        state_next = S_IDLE;
                    else
                    begin
                        cur_next = tgt_reg;
                        stp_next = stp_reg + 1'b1;
                        rd_en = 1'b1;
                        rd_addr = tgt_reg[AW-1:0];
                        state_next = S_EVAL;
                    end
                end
            end
            S_UPD:
            begin
                // read of free head next pointer issued on the first pass of an insert
                case (upd_reg)
                    2'd3:
                    begin
                        // finish insert: free_head <= next of taken entry
                        free_next  = rd_nxt;
                        count_next = count_reg + 1'b1;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                        if (req_reg == REQ_DEL_FRONT)
                        begin
                            wn_en = 1'b1; wn_addr = head_reg[AW-1:0]; wn_data = free_reg;
                            free_next = head_reg;
                            head_next = rd_nxt;
                            if (count_reg != '0) count_next = count_reg - 1'b1;
                        end
                        else if (req_reg == REQ_DEL_BACK || req_reg == REQ_DEL_KEY)
                        begin
                            wn_en = 1'b1; wn_addr = cur_reg[AW-1:0]; wn_data = free_reg;
                            free_next = cur_reg;
                            if (count_reg != '0) count_next = count_reg - 1'b1;
                            if (prv_reg >= NUL)
                                head_next = (req_reg == REQ_DEL_BACK) ? rd_nxt : tgt_reg;
                            else
                            begin
                                upd_next = 2'd3;
                                tgt_next = (req_reg == REQ_DEL_BACK) ? rd_nxt : tgt_reg;
                                state_next = S_UPD;
                                // link fix done next cycle
                            end
                        end
                        else
                        begin
                            // insert: write value and link of new entry, read its old next
                            wv_en = 1'b1;
                            wn_en = 1'b1;
                            rd_en = 1'b1;
                            rd_addr = free_reg[AW-1:0];
                            case (req_reg)
                                REQ_INS_FRONT:  wn_data = head_reg;
                                REQ_INS_BACK:   wn_data = NUL;
                                REQ_INS_BEFORE: wn_data = cur_reg;
                                default:        wn_data = tgt_reg;
                            endcase
                            upd_next = 2'd3;
                            state_next = S_UPD;
                        end
                    end
                endcase
                if (upd_reg == 2'd3 && (req_reg == REQ_DEL_BACK || req_reg == REQ_DEL_KEY))
                begin
                    wn_en = 1'b1; wn_addr = prv_reg[AW-1:0]; wn_data = tgt_reg;
                    free_next = free_reg;
                    count_next = count_reg;
                end
                else if (upd_reg == 2'd3)
                begin
                    // hook new entry into its predecessor, or make it the head
                    case (req_reg)
                        REQ_INS_FRONT:
                            head_next = free_reg;
                        REQ_INS_BACK:
                        begin
                            if (head_reg >= NUL) head_next = free_reg;
                            else begin wn_en = 1'b1; wn_addr = cur_reg[AW-1:0];
                                wn_data = free_reg; end
                        end
                        REQ_INS_BEFORE:
                        begin
                            if (prv_reg >= NUL) head_next = free_reg;
                            else begin wn_en = 1'b1; wn_addr = prv_reg[AW-1:0];
                                wn_data = free_reg; end
                        end
                        default:
                        begin
                            wn_en = 1'b1; wn_addr = cur_reg[AW-1:0]; wn_data = free_reg;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (res_space)
                begin
                    res_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // the dump walk keeps the next link in tgt
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            head_reg  <= NUL;
            free_reg  <= '0;
            count_reg <= '0;
            clr_reg   <= '0;
            cur_reg   <= '0;
            prv_reg   <= '0;
            stp_reg   <= '0;
            upd_reg   <= '0;
            tgt_reg   <= '0;
            res_reg   <= '0;
            res_last_emit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            cur_reg   <= cur_next;
            prv_reg   <= prv_next;
            stp_reg   <= stp_next;
            upd_reg   <= upd_next;
            tgt_reg   <= (state_reg == S_EVAL && req_reg == REQ_DUMP) ? rd_nxt : tgt_next;
            res_reg   <= res_next;
            res_last_emit_reg <= res_push && res_reg.last;
        end
    end

    `OLE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= NUL)
    `OLE_ASSERT_IMPL(a_push_space, res_push, res_space)
    `OLE_ASSERT_NEXT(a_last_idle, res_push && res_reg.last, state_reg == S_IDLE)
    `OLE_ASSERT_IMPL(a_last_flag, res_last_emit_reg, state_reg != S_WALK)
endmodule

// ----- sv/ordered_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of signed 32-bit values kept as linked entries in memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, results leave on m_axis.
// One request is worked at a time: the sequencer walks the link memory
// one entry per cycle (one read of the synchronous link/value memory each)
// when it seeks a key or the tail, then updates the links in S_UPD and
// sends the result from S_EMIT.
// A dump gives one result per entry, front first, tlast on the final one;
// it fetches the next entry only once the result before has been pushed.
// Every other request gives one result with tlast set.
// s_axis_tready is high only while the sequencer is idle and no result waits.
// After reset a clearing pass over all CAPACITY entries builds the free chain;
// s_axis_tready stays low during it.
// When the receiver stalls, results wait in the output buffer and the
// walk pauses; no result is lost or repeated.
// ----------------------------------------------------------------------------
module ordered_list_engine_top
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // req_type[3:0], key[35:4], value[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0], position[7:2], data[39:8]
    output logic        m_axis_tlast
);
    logic    core_idle, buf_space, buf_empty, push, start;
    result_t push_data, out_data;

    assign s_axis_tready = core_idle && buf_empty;
    assign start = s_axis_tvalid && s_axis_tready;

    ole_core #(.CAPACITY(CAPACITY)) u_core (
        .clk(clk), .rst_n(rst_n), .start(start),
        .req_type(s_axis_tdata[3:0]), .key(s_axis_tdata[35:4]),
        .value(s_axis_tdata[67:36]), .idle(core_idle),
        .res_space(buf_space), .res_push(push), .res_data(push_data)
    );

    ole_out_buf u_buf (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .space(buf_space), .empty(buf_empty), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .out_data(out_data)
    );

    assign m_axis_tdata = {out_data.data, out_data.position, out_data.status};
    assign m_axis_tlast = out_data.last;
endmodule

// ----- dv/tb_ordered_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// Self-checking bench for the ordered list engine.
// ----------------------------------------------------------------------------
// Requests go in on s_axis with random bursts and gaps; results are checked
// on m_axis against a linked-list predictor kept in the bench, in order,
// field by field. The receiver stalls on its own pattern, once for a long
// stretch so the engine backs up.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top
    import ole_pkg::*;
();

    localparam int CAP    = CAPACITY_DEF;
    localparam int NULL_IX = CAP;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] data;
        logic        last;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    ordered_list_engine_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // predictor copy of the list
    logic [31:0] node_val [CAP];
    int          node_nxt [CAP];
    int          list_head;
    int          free_top;
    int          list_len;

    list_result_t expected_results[$];
    int  error_count;
    int  cycle_count;
    int  hold_cycles;
    bit  hold_off;

    task automatic report_mismatch(input string msg);
        begin
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
            error_count++;
        end
    endtask

    function automatic void list_reset();
        for (int i = 0; i < CAP; i++)
        begin
            node_val[i] = '0;
            node_nxt[i] = i + 1;
        end
        list_head = NULL_IX;
        free_top  = 0;
        list_len  = 0;
    endfunction

    function automatic void push_result(logic [1:0] st, logic [5:0] pos,
                                        logic [31:0] d, logic l);
        list_result_t r;
        r.status = st; r.position = pos; r.data = d; r.last = l;
        expected_results.push_back(r);
    endfunction

    // first match: returns index or null, prev and 1-based position
    function automatic int locate_key(input logic [31:0] k, output int prv,
                                      output int pos);
        int p, c, n;
        p = NULL_IX; c = list_head; n = 1;
        for (int g = 0; g < CAP && c < NULL_IX; g++)
        begin
            if (node_val[c] == k)
            begin
                prv = p; pos = n;
                return c;
            end
            p = c; c = node_nxt[c]; n++;
        end
        prv = p; pos = 0;
        return NULL_IX;
    endfunction

    function automatic int locate_tail(output int prv);
        int p, c;
        p = NULL_IX; c = list_head; prv = NULL_IX;
        if (c >= NULL_IX)
            return NULL_IX;
        for (int g = 1; g < CAP && node_nxt[c] < NULL_IX; g++)
        begin
            p = c; c = node_nxt[c];
        end
        prv = p;
        return c;
    endfunction

    function automatic int alloc_node(logic [31:0] v);
        int i;
        i = free_top;
        free_top = node_nxt[i];
        node_val[i] = v;
        list_len++;
        return i;
    endfunction

    function automatic void unlink_node(int p, int c);
        if (p < NULL_IX)
            node_nxt[p] = node_nxt[c];
        else
            list_head = node_nxt[c];
        node_nxt[c] = free_top;
        free_top = c;
        if (list_len > 0)
            list_len--;
    endfunction

    function automatic void predict_request(logic [3:0] req, logic [31:0] k,
                                            logic [31:0] v);
        int prv, pos, c, ix, nx;
        bit full;
        full = (free_top >= NULL_IX) || (list_len >= CAP);
        if (req <= REQ_INS_AFTER && full)
        begin
            push_result(ST_FULL, '0, '0, 1'b1);
            return;
        end
        case (req)
            REQ_INS_FRONT:
            begin
                ix = alloc_node(v);
                node_nxt[ix] = list_head;
                list_head = ix;
            end
            REQ_INS_BACK:
            begin
                c = locate_tail(prv);
                ix = alloc_node(v);
                node_nxt[ix] = NULL_IX;
                if (c < NULL_IX) node_nxt[c] = ix;
                else list_head = ix;
            end
            REQ_INS_BEFORE, REQ_INS_AFTER, REQ_DEL_KEY, REQ_SEARCH:
            begin
                c = locate_key(k, prv, pos);
                if (c >= NULL_IX)
                begin
                    push_result(ST_MISS, '0, '0, 1'b1);
                    return;
                end
                if (req == REQ_INS_BEFORE)
                begin
                    ix = alloc_node(v);
                    node_nxt[ix] = c;
                    if (prv < NULL_IX) node_nxt[prv] = ix;
                    else list_head = ix;
                end
                else if (req == REQ_INS_AFTER)
                begin
                    ix = alloc_node(v);
                    node_nxt[ix] = node_nxt[c];
                    node_nxt[c] = ix;
                end
                else if (req == REQ_DEL_KEY)
                    unlink_node(prv, c);
                else
                begin
                    push_result(ST_DONE, pos[5:0], '0, 1'b1);
                    return;
                end
            end
            REQ_DEL_FRONT:
            begin
                if (list_head >= NULL_IX)
                begin
                    push_result(ST_MISS, '0, '0, 1'b1);
                    return;
                end
                unlink_node(NULL_IX, list_head);
            end
            REQ_DEL_BACK:
            begin
                c = locate_tail(prv);
                if (c >= NULL_IX)
                begin
                    push_result(ST_MISS, '0, '0, 1'b1);
                    return;
                end
                unlink_node(prv, c);
            end
            REQ_DUMP:
            begin
                c = list_head;
                if (c >= NULL_IX)
                begin
                    push_result(ST_MISS, '0, '0, 1'b1);
                    return;
                end
                for (int g = 0; g < CAP && c < NULL_IX; g++)
                begin
                    nx = node_nxt[c];
                    push_result(ST_DONE, '0, node_val[c],
                                (nx >= NULL_IX) || (g + 1 >= CAP));
                    c = nx;
                end
                return;
            end
            default: ;
        endcase
        push_result(ST_DONE, '0, '0, 1'b1);
    endfunction

    // sender burst state
    int burst_left;

    task automatic send_request(input logic [3:0] req, input logic [31:0] k,
                                input logic [31:0] v);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                    s_axis_tvalid <= 1'b0;
                for (int i = 0; i < gap; i++)
                    @(posedge clk);
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'b0, v, k, req};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            predict_request(req, k, v);
        end
    endtask

    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (CAP + 8) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // pick a key that is in the list most of the time
    function automatic logic [31:0] pick_key();
        int c, n;
        if (list_head < NULL_IX && $urandom_range(0, 3) != 0)
        begin
            n = $urandom_range(0, list_len - 1);
            c = list_head;
            for (int i = 0; i < n && node_nxt[c] < NULL_IX; i++)
                c = node_nxt[c];
            return node_val[c];
        end
        return pick_value();
    endfunction

    task automatic test_directed();
        begin
            send_request(REQ_DUMP, 0, 0);
            send_request(REQ_DEL_FRONT, 0, 0);
            send_request(REQ_DEL_BACK, 0, 0);
            send_request(REQ_DEL_KEY, 5, 0);
            send_request(REQ_SEARCH, 5, 0);
            send_request(REQ_INS_BEFORE, 5, 1);
            send_request(REQ_INS_AFTER, 5, 1);
            send_request(REQ_INS_FRONT, 0, 32'h7FFF_FFFF);
            send_request(REQ_INS_BACK, 0, 32'h8000_0000);
            send_request(REQ_INS_BEFORE, 32'h8000_0000, 32'hFFFF_FFFF);
            send_request(REQ_INS_AFTER, 32'h7FFF_FFFF, 32'h0000_0000);
            send_request(REQ_INS_BACK, 0, 32'h7FFF_FFFF);
            send_request(REQ_SEARCH, 32'h7FFF_FFFF, 0);
            send_request(REQ_SEARCH, 32'h8000_0000, 0);
            send_request(REQ_DUMP, 0, 0);
            send_request(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_request(4'd15, 0, 0);
            send_request(REQ_DEL_KEY, 32'h7FFF_FFFF, 0);
            send_request(REQ_DEL_BACK, 0, 0);
            send_request(REQ_DEL_FRONT, 0, 0);
            send_request(REQ_DUMP, 0, 0);
        end
    endtask

    // fill to capacity, hit the full cases, search it, dump the whole list, empty it
    task automatic test_full_list();
        begin
            while (list_len < CAP)
                send_request($urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK,
                             0, $urandom);
            send_request(REQ_INS_FRONT, 0, 1);
            send_request(REQ_INS_BACK, 0, 1);
            send_request(REQ_INS_BEFORE, 32'h1234_5678, 1);
            send_request(REQ_INS_AFTER, pick_key(), 1);
            send_request(REQ_SEARCH, pick_key(), 0);
            send_request(REQ_DUMP, 0, 0);
            while (list_len > 0)
                send_request(4'($urandom_range(REQ_DEL_FRONT, REQ_DEL_KEY)),
                             pick_key(), 0);
        end
    endtask

    task automatic test_random(input int count);
        logic [3:0] req;
        begin
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    req = REQ_INS_FRONT;
                    3, 4, 5:    req = REQ_INS_BACK;
                    6, 7:       req = REQ_INS_BEFORE;
                    8, 9:       req = REQ_INS_AFTER;
                    10:         req = REQ_DEL_FRONT;
                    11:         req = REQ_DEL_BACK;
                    12, 13:     req = REQ_DEL_KEY;
                    14, 15, 16: req = REQ_SEARCH;
                    17, 18:     req = REQ_DUMP;
                    default:    req = 4'($urandom_range(9, 15));
                endcase
                send_request(req, pick_key(), pick_value());
            end
        end
    endtask

    // sender keeps pushing while the receiver holds off
    task automatic test_backpressure();
        begin
            hold_off = 1'b1;
            test_random(30);
            wait_drained();
        end
    endtask

    // receiver: own stall pattern, and a long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= (hold_cycles >= HOLD_LEN - 1) ? 0 : hold_cycles + 1;
            if (hold_cycles >= HOLD_LEN - 1)
                hold_off <= 1'b0;
        end
        else if ((cycle_count / 200) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[1:0], m_axis_tdata[7:2], m_axis_tdata[39:8],
                   m_axis_tlast};
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d",
                                              got.status, exp_r.status));
                if (got.position !== exp_r.position)
                    report_mismatch($sformatf("position %0d exp %0d",
                                              got.position, exp_r.position));
                if (got.data !== exp_r.data)
                    report_mismatch($sformatf("data %h exp %h",
                                              got.data, exp_r.data));
                if (got.last !== exp_r.last)
                    report_mismatch($sformatf("last %0b exp %0b",
                                              got.last, exp_r.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        hold_off    = 1'b0;
        burst_left  = 0;
        list_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random(120);
        // pause until everything is back
        wait_drained();
        test_backpressure();
        test_random(100);
        wait_drained();
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/ole_pkg.sv
sv/ole_out_buf.sv
sv/ole_core.sv
sv/ordered_list_engine_top.sv
dv/tb_ordered_list_engine_top.sv
